// File: hw/rtl/sshe_pkg.sv
// Package with the shared types and constants of the selectable string hash engine.
`default_nettype none

package sshe_pkg;

  // Algorithm codes held in the selector register.
  typedef enum logic [3:0] {
    ALG_RS   = 4'd0,
    ALG_JS   = 4'd1,
    ALG_PJW  = 4'd2,
    ALG_ELF  = 4'd3,
    ALG_BKDR = 4'd4,
    ALG_SDBM = 4'd5,
    ALG_DJB  = 4'd6,
    ALG_DEK  = 4'd7,
    ALG_BP   = 4'd8,
    ALG_FNV  = 4'd9,
    ALG_AP   = 4'd10
  } alg_e;

  // Configuration register indexes.
  localparam logic CfgIdxAlg  = 1'b0;
  localparam logic CfgIdxSext = 1'b1;

  localparam int unsigned CfgDataW = 4;

  // Hash constants.
  localparam logic [31:0] RsB       = 32'd378551;
  localparam logic [31:0] RsA0      = 32'd63689;
  localparam logic [31:0] JsInit    = 32'd1315423911;
  localparam logic [31:0] BkdrSeed  = 32'd131;
  localparam logic [31:0] DjbInit   = 32'd5381;
  localparam logic [31:0] FnvMult   = 32'h811C_9DC5;
  localparam logic [31:0] ApInit    = 32'hAAAA_AAAA;
  localparam logic [31:0] TopNibble = 32'hF000_0000;

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        byte_present;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] string_length;
  } item_t;

  // Hash state carried from item to item.
  typedef struct packed {
    logic [31:0] running_hash;
    logic [31:0] rs_multiplier;
    logic        position_odd;
  } hash_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/sshe_in_reg.sv
// Input register stage that holds one item and drives the input stall.
`default_nettype none

module sshe_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sshe_pkg::item_t item_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output sshe_pkg::item_t    item_o
);
  import sshe_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // The register is free when empty or when its item moves on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: hw/rtl/sshe_mix.sv
// Combinational hash step: reload on a first item, then mix in the byte if one is present.
`default_nettype none

module sshe_mix (
  input  wire logic [3:0]          alg_i,
  input  wire logic                sext_i,
  input  wire sshe_pkg::item_t     item_i,
  input  wire sshe_pkg::hash_state_t state_i,
  output sshe_pkg::hash_state_t    state_o
);
  import sshe_pkg::*;

  logic [31:0] start_hash;
  logic [31:0] h;
  logic [31:0] rsm;
  logic        pos;
  logic [31:0] c;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] shl4;
  logic [31:0] top;
  logic [31:0] mixed;

  // Starting hash of the selected algorithm.
  always_comb begin
    case (alg_i)
      ALG_JS:  start_hash = JsInit;
      ALG_DJB: start_hash = DjbInit;
      ALG_DEK: start_hash = item_i.string_length;
      ALG_AP:  start_hash = ApInit;
      default: start_hash = '0;
    endcase
  end

  // Effective state after an optional reload.
  assign h   = item_i.first_byte ? start_hash : state_i.running_hash;
  assign rsm = item_i.first_byte ? RsA0 : state_i.rs_multiplier;
  assign pos = item_i.first_byte ? 1'b0 : state_i.position_odd;

  // Byte widened to 32 bits, signed or unsigned.
  assign c = {{24{sext_i & item_i.byte_value[7]}}, item_i.byte_value};

  // One shared multiplier serves RS, BKDR, FNV and the even AP step.
  always_comb begin
    case (alg_i)
      ALG_RS: begin
        mul_a = h;
        mul_b = rsm;
      end
      ALG_BKDR: begin
        mul_a = h;
        mul_b = BkdrSeed;
      end
      ALG_FNV: begin
        mul_a = h;
        mul_b = FnvMult;
      end
      ALG_AP: begin
        mul_a = c;
        mul_b = h >> 3;
      end
      default: begin
        mul_a = h;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared terms of PJW and ELF.
  assign shl4 = (h << 4) + c;
  assign top  = shl4 & TopNibble;

  // Mixing step of the selected algorithm.
  always_comb begin
    case (alg_i)
      ALG_RS:   mixed = mul_p + c;
      ALG_JS:   mixed = h ^ ((h << 5) + c + (h >> 2));
      ALG_PJW: begin
        if (top != '0) begin
          mixed = (shl4 ^ (top >> 24)) & ~TopNibble;
        end else begin
          mixed = shl4;
        end
      end
      ALG_ELF: begin
        if (top != '0) begin
          mixed = (shl4 ^ (top >> 24)) & ~top;
        end else begin
          mixed = shl4;
        end
      end
      ALG_BKDR: mixed = mul_p + c;
      ALG_SDBM: mixed = c + (h << 6) + (h << 16) - h;
      ALG_DJB:  mixed = (h << 5) + h + c;
      ALG_DEK:  mixed = ((h << 5) ^ (h >> 27)) ^ c;
      ALG_BP:   mixed = (h << 7) ^ c;
      ALG_FNV:  mixed = mul_p ^ c;
      ALG_AP: begin
        if (!pos) begin
          mixed = h ^ ((h << 7) ^ mul_p);
        end else begin
          mixed = h ^ ~((h << 11) + (c ^ (h >> 5)));
        end
      end
      default:  mixed = h;
    endcase
  end

  // Without a byte the state stays as reloaded.
  always_comb begin
    if (item_i.byte_present) begin
      state_o.running_hash  = mixed;
      state_o.rs_multiplier = rsm * RsB;
      state_o.position_odd  = ~pos;
    end else begin
      state_o.running_hash  = h;
      state_o.rs_multiplier = rsm;
      state_o.position_odd  = pos;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/selectable_string_hash_engine_top.sv
// Top level of the selectable string hash engine: config, state and result register.
// A string's hash is registered as its last-byte item leaves the input register.
// Throughput: one item per cycle while no held result blocks; hash feedback uses a 32-bit multiplier.
// A held result blocks only items that carry the last byte and would need the result register.
// Reset clears both valids, sets the selector to RS and byte sign extension on,
// and loads the starting hash state (hash 0, RS multiplier 63689, even position).
`default_nettype none

module selectable_string_hash_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        byte_present_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [31:0] string_length_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_value_o
);
  import sshe_pkg::*;

  logic [3:0]  alg_q;
  logic        sext_q;
  item_t       in_item;
  item_t       cur_item;
  logic        cur_valid;
  logic        advance;
  hash_state_t state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hash_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q  <= ALG_RS;
      sext_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgIdxAlg:  alg_q  <= cfg_data_i;
        CfgIdxSext: sext_q <= cfg_data_i[0];
        default:    alg_q  <= alg_q;
      endcase
    end
  end

  assign in_item.byte_value    = byte_value_i;
  assign in_item.byte_present  = byte_present_i;
  assign in_item.first_byte    = first_byte_i;
  assign in_item.last_byte     = last_byte_i;
  assign in_item.string_length = string_length_i;

  // Input register.
  sshe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  // The held item moves on unless it needs a result register that is still full.
  assign advance = cur_valid &&
                   (!cur_item.last_byte || !out_valid_q || !out_stall_i);

  // Hash step.
  sshe_mix u_mix (
    .alg_i   (alg_q),
    .sext_i  (sext_q),
    .item_i  (cur_item),
    .state_i (state_q),
    .state_o (state_d)
  );

  // Running hash state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.running_hash  <= '0;
      state_q.rs_multiplier <= RsA0;
      state_q.position_odd  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && cur_item.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cur_item.last_byte) begin
      hash_q <= state_d.running_hash;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire
